@@ src/distance_vector_table_update_macros.svh @@
// -----------------------------------------------------------------------------
// Assertion macros for the distance vector table update block
// Shared property forms, clocked and disabled during reset.
// -----------------------------------------------------------------------------
`ifndef DISTANCE_VECTOR_TABLE_UPDATE_MACROS_SVH
`define DISTANCE_VECTOR_TABLE_UPDATE_MACROS_SVH

// same-cycle implication
`define DVTU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dvtu same-cycle check failed");

// next-cycle implication
`define DVTU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dvtu next-cycle check failed");

`endif

@@ src/dvtu_pkg.sv @@
// -----------------------------------------------------------------------------
// dvtu_pkg
// Types and fixed constants of the distance vector table update block.
// -----------------------------------------------------------------------------
`default_nettype none

package dvtu_pkg;

    typedef enum logic [0:0] {
        CMD_LOAD = 1'b0,
        CMD_ADV  = 1'b1
    } t_cmd;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_dp_cmd;

    localparam logic signed [3:0]  VIA_UNKNOWN = 4'sb1111;
    localparam logic signed [3:0]  VIA_SELF    = 4'sb1110;
    localparam logic signed [15:0] CIN_UNKNOWN = 16'shFFFF;
    localparam logic signed [15:0] CIN_SELF    = 16'shFFFE;
    localparam logic [15:0]        QUIET_MAX   = 16'hFFFF;

endpackage

`default_nettype wire

@@ src/dvtu_ctrl.sv @@
// -----------------------------------------------------------------------------
// dvtu_ctrl
// Sequencer: capture and table read, then commit of write and result once
// the output register is free. Owns the handshakes and the result valid.
// -----------------------------------------------------------------------------
`default_nettype none

`include "distance_vector_table_update_macros.svh"

module dvtu_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output dvtu_pkg::t_dp_cmd     o_dp_cmd
);

    dvtu_pkg::t_state r_state;
    dvtu_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            dvtu_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = dvtu_pkg::ST_EXEC;
                end
            end
            dvtu_pkg::ST_EXEC: begin
                if (out_free) begin
                    n_state = dvtu_pkg::ST_IDLE;
                end
            end
            default: n_state = dvtu_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_dp_cmd.capture = 1'b0;
        o_dp_cmd.commit  = 1'b0;
        o_in_stall       = 1'b1;
        n_out_valid      = r_out_valid && i_out_stall;
        case (r_state)
            dvtu_pkg::ST_IDLE: begin
                o_in_stall       = 1'b0;
                o_dp_cmd.capture = i_in_valid;
            end
            dvtu_pkg::ST_EXEC: begin
                if (out_free) begin
                    o_dp_cmd.commit = 1'b1;
                    n_out_valid     = 1'b1;
                end
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dvtu_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `DVTU_ASSERT_NEXT(a_capture_to_exec, i_clk, i_rst_n, o_dp_cmd.capture, r_state == dvtu_pkg::ST_EXEC)
    `DVTU_ASSERT_NEXT(a_commit_shows_result, i_clk, i_rst_n, o_dp_cmd.commit, o_out_valid && (r_state == dvtu_pkg::ST_IDLE))
    `DVTU_ASSERT_NOW(a_cmd_exclusive, i_clk, i_rst_n, 1'b1, $onehot0({o_dp_cmd.capture, o_dp_cmd.commit}))

endmodule

`default_nettype wire

@@ src/dvtu_datapath.sv @@
// -----------------------------------------------------------------------------
// dvtu_datapath
// Routing table register file (two read ports, one write port), relaxation
// add/compare, saturation, vector change flag, quiet counter, result regs.
// -----------------------------------------------------------------------------
`default_nettype none

module dvtu_datapath #(
    parameter int NODES     = 8,
    parameter int COST_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire dvtu_pkg::t_dp_cmd     i_dp_cmd,
    input  wire logic [2:0]            i_self_index,
    input  wire logic                  i_cmd,
    input  wire logic [2:0]            i_sender,
    input  wire logic [2:0]            i_dest,
    input  wire logic signed [15:0]    i_cost_in,
    input  wire logic                  i_is_neighbour,
    input  wire logic                  i_last,
    output logic [2:0]                 o_entry_dest,
    output logic signed [15:0]         o_entry_cost,
    output logic signed [3:0]          o_entry_via,
    output logic                       o_changed,
    output logic                       o_vector_updated,
    output logic [15:0]                o_quiet_rounds
);

    localparam int IW = $clog2(NODES);
    localparam int SW = ((COST_BITS > 16) ? COST_BITS : 16) + 1;
    localparam logic [4:0] NODES_W = 5'(NODES);

    localparam logic signed [COST_BITS-1:0] T_UNK  = '1;
    localparam logic signed [COST_BITS-1:0] T_SELF = {{(COST_BITS-1){1'b1}}, 1'b0};
    localparam logic signed [SW-1:0] C_MAX = {{(SW-COST_BITS+1){1'b0}}, {(COST_BITS-1){1'b1}}};
    localparam logic signed [SW-1:0] C_MIN = ~C_MAX;
    localparam logic signed [SW-1:0] O_MAX = {{(SW-15){1'b0}}, {15{1'b1}}};
    localparam logic signed [SW-1:0] O_MIN = ~O_MAX;
    localparam logic signed [SW-1:0] X_ONE = {{(SW-1){1'b0}}, 1'b1};
    localparam logic signed [SW-1:0] X_UNK = '1;

    logic signed [COST_BITS-1:0] mem_cost [NODES];
    logic signed [3:0]           mem_via  [NODES];
    logic [NODES-1:0]            r_vld;

    logic                        r_cmd;
    logic [2:0]                  r_sender;
    logic [2:0]                  r_dest;
    logic signed [15:0]          r_cost_in;
    logic                        r_nb;
    logic                        r_last;
    logic signed [COST_BITS-1:0] r_s_cost;
    logic signed [COST_BITS-1:0] r_d_cost;
    logic signed [3:0]           r_s_via;
    logic signed [3:0]           r_d_via;
    logic                        r_s_vld;
    logic                        r_d_vld;

    logic                        r_flag;
    logic                        n_flag;
    logic [15:0]                 r_quiet;
    logic [15:0]                 n_quiet;

    logic [2:0]                  r_entry_dest;
    logic signed [15:0]          r_entry_cost;
    logic signed [3:0]           r_entry_via;
    logic                        r_changed;
    logic                        r_vupd;

    logic signed [COST_BITS-1:0] s_cost;
    logic signed [COST_BITS-1:0] d_cost;
    logic signed [3:0]           s_via;
    logic signed [3:0]           d_via;
    logic signed [SW-1:0]        c_ext;
    logic signed [SW-1:0]        s_ext;
    logic signed [SW-1:0]        d_ext;
    logic signed [SW-1:0]        sum;
    logic signed [SW-1:0]        cand;
    logic signed [SW-1:0]        cand_sat;
    logic signed [SW-1:0]        rc_ext;
    logic signed [SW-1:0]        rc_sat;
    logic                        is_load;
    logic                        is_adv;
    logic                        dst_ok;
    logic                        snd_ok;
    logic                        c_ok;
    logic                        upd;
    logic                        hit_self;
    logic                        wr_en;
    logic signed [COST_BITS-1:0] wr_cost;
    logic signed [3:0]           wr_via;
    logic signed [COST_BITS-1:0] new_cost;
    logic signed [3:0]           new_via;
    logic signed [COST_BITS-1:0] rc;
    logic signed [3:0]           rv;
    logic                        flag_mid;
    logic [15:0]                 quiet_mid;
    logic                        vupd;

    // capture and registered table read
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.capture) begin
            r_cmd     <= i_cmd;
            r_sender  <= i_sender;
            r_dest    <= i_dest;
            r_cost_in <= i_cost_in;
            r_nb      <= i_is_neighbour;
            r_last    <= i_last;
            r_s_cost  <= mem_cost[IW'(i_sender)];
            r_d_cost  <= mem_cost[IW'(i_dest)];
            r_s_via   <= mem_via[IW'(i_sender)];
            r_d_via   <= mem_via[IW'(i_dest)];
            r_s_vld   <= r_vld[IW'(i_sender)];
            r_d_vld   <= r_vld[IW'(i_dest)];
        end
    end

    assign is_load  = (r_cmd == dvtu_pkg::CMD_LOAD);
    assign is_adv   = (r_cmd == dvtu_pkg::CMD_ADV);
    assign dst_ok   = {2'b00, r_dest} < NODES_W;
    assign snd_ok   = {2'b00, r_sender} < NODES_W;
    assign c_ok     = (r_cost_in != dvtu_pkg::CIN_UNKNOWN) && (r_cost_in != dvtu_pkg::CIN_SELF);

    // never-written entries read as unknown
    assign s_cost   = r_s_vld ? r_s_cost : T_UNK;
    assign d_cost   = r_d_vld ? r_d_cost : T_UNK;
    assign s_via    = r_s_vld ? r_s_via : dvtu_pkg::VIA_UNKNOWN;
    assign d_via    = r_d_vld ? r_d_via : dvtu_pkg::VIA_UNKNOWN;

    assign c_ext    = {{(SW-16){r_cost_in[15]}}, r_cost_in};
    assign s_ext    = {{(SW-COST_BITS){s_cost[COST_BITS-1]}}, s_cost};
    assign d_ext    = {{(SW-COST_BITS){d_cost[COST_BITS-1]}}, d_cost};
    assign sum      = c_ext + s_ext;

    // direct cost-1 entries are protected unless unknown
    assign upd      = is_adv && dst_ok && snd_ok && c_ok &&
                      (((sum < d_ext) && (d_ext != X_ONE)) || (d_ext == X_UNK));
    assign hit_self = is_load && (r_dest == i_self_index);
    assign wr_en    = (is_load && dst_ok) || upd;

    assign cand     = is_load ? c_ext : sum;
    assign cand_sat = (cand > C_MAX) ? C_MAX : ((cand < C_MIN) ? C_MIN : cand);

    always_comb begin
        if (hit_self) begin
            wr_cost = T_SELF;
            wr_via  = dvtu_pkg::VIA_SELF;
        end else if (is_load) begin
            wr_cost = cand_sat[COST_BITS-1:0];
            wr_via  = r_nb ? {1'b0, r_dest} : dvtu_pkg::VIA_UNKNOWN;
        end else begin
            wr_cost = cand_sat[COST_BITS-1:0];
            wr_via  = s_via;
        end
    end

    assign new_cost = wr_en ? wr_cost : d_cost;
    assign new_via  = wr_en ? wr_via : d_via;
    assign rc       = dst_ok ? new_cost : T_UNK;
    assign rv       = dst_ok ? new_via : dvtu_pkg::VIA_UNKNOWN;
    assign rc_ext   = {{(SW-COST_BITS){rc[COST_BITS-1]}}, rc};
    assign rc_sat   = (rc_ext > O_MAX) ? O_MAX : ((rc_ext < O_MIN) ? O_MIN : rc_ext);

    assign flag_mid  = r_flag || upd;
    assign quiet_mid = upd ? 16'd0 : r_quiet;

    always_comb begin
        n_flag  = flag_mid;
        n_quiet = quiet_mid;
        vupd    = 1'b0;
        if (is_adv && r_last) begin
            vupd   = flag_mid;
            n_flag = 1'b0;
            if (!flag_mid && (quiet_mid != dvtu_pkg::QUIET_MAX)) begin
                n_quiet = quiet_mid + 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.commit && wr_en) begin
            mem_cost[IW'(r_dest)] <= wr_cost;
            mem_via[IW'(r_dest)]  <= wr_via;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_flag  <= 1'b0;
            r_quiet <= 16'd0;
        end else if (i_dp_cmd.commit) begin
            if (wr_en) begin
                r_vld[IW'(r_dest)] <= 1'b1;
            end
            r_flag  <= n_flag;
            r_quiet <= n_quiet;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.commit) begin
            r_entry_dest <= r_dest;
            r_entry_cost <= rc_sat[15:0];
            r_entry_via  <= rv;
            r_changed    <= upd;
            r_vupd       <= vupd;
        end
    end

    assign o_entry_dest     = r_entry_dest;
    assign o_entry_cost     = r_entry_cost;
    assign o_entry_via      = r_entry_via;
    assign o_changed        = r_changed;
    assign o_vector_updated = r_vupd;
    assign o_quiet_rounds   = r_quiet;

endmodule

`default_nettype wire

@@ src/distance_vector_table_update.sv @@
// A taken item is captured with its table read; its write and result commit
// once the output register is free. No new item is taken until then, as the
// table read is followed by the write into the routing table register file.
// Reset (synchronous, active low): all costs and next hops unknown,
// change flag and quiet count cleared, self index 0. No clearing pass.
// -----------------------------------------------------------------------------
// distance_vector_table_update
// Distance vector routing table: loads entries and relaxes them through
// advertised vectors, tracking vectors in a row that changed nothing.
// -----------------------------------------------------------------------------
`default_nettype none

module distance_vector_table_update #(
    parameter int NODES     = 8,
    parameter int COST_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_cmd,
    input  wire logic [2:0]         i_sender,
    input  wire logic [2:0]         i_dest,
    input  wire logic signed [15:0] i_cost_in,
    input  wire logic               i_is_neighbour,
    input  wire logic               i_last,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [2:0]              o_entry_dest,
    output logic signed [15:0]      o_entry_cost,
    output logic signed [3:0]       o_entry_via,
    output logic                    o_changed,
    output logic                    o_vector_updated,
    output logic [15:0]             o_quiet_rounds
);

    logic [2:0]         r_self_index;
    dvtu_pkg::t_dp_cmd  dp_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self_index <= 3'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_self_index <= i_cfg_data;
        end
    end

    dvtu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_dp_cmd    (dp_cmd)
    );

    dvtu_datapath #(
        .NODES     (NODES),
        .COST_BITS (COST_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_dp_cmd         (dp_cmd),
        .i_self_index     (r_self_index),
        .i_cmd            (i_cmd),
        .i_sender         (i_sender),
        .i_dest           (i_dest),
        .i_cost_in        (i_cost_in),
        .i_is_neighbour   (i_is_neighbour),
        .i_last           (i_last),
        .o_entry_dest     (o_entry_dest),
        .o_entry_cost     (o_entry_cost),
        .o_entry_via      (o_entry_via),
        .o_changed        (o_changed),
        .o_vector_updated (o_vector_updated),
        .o_quiet_rounds   (o_quiet_rounds)
    );

endmodule

`default_nettype wire

@@ tb/distance_vector_table_update_tb.sv @@
// -----------------------------------------------------------------------------
// distance_vector_table_update_tb
// Self-checking bench for the routing table update block. Load and advertise
// transfers are sent through the valid/stall input port. Each accepted
// transfer is run through a local copy of the routing table to build the
// expected report, and every report that leaves the block is compared field
// by field in arrival order. Directed cases cover loads, the relaxation rule
// and its guards, self index changes and runs of quiet vectors. Random
// vectors then run under four sender and receiver idling patterns.
// -----------------------------------------------------------------------------
`default_nettype none

module distance_vector_table_update_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        dvtu_pkg::t_cmd     cmd;
        logic [2:0]         sender;
        logic [2:0]         dest;
        logic signed [15:0] cost;
        logic               nb;
        logic               last;
    } t_route_item;

    typedef struct packed {
        logic [2:0]         dest;
        logic signed [15:0] cost;
        logic signed [3:0]  via;
        logic               changed;
        logic               vupd;
        logic [15:0]        quiet;
    } t_route_report;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               in_cmd = 1'b0;
    logic [2:0]         in_sender = '0;
    logic [2:0]         in_dest = '0;
    logic signed [15:0] in_cost = '0;
    logic               in_nb = 1'b0;
    logic               in_last = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [2:0]         out_dest;
    logic signed [15:0] out_cost;
    logic signed [3:0]  out_via;
    logic               out_changed;
    logic               out_vupd;
    logic [15:0]        out_quiet;

    // local routing table
    logic signed [15:0] cost_tab [8];
    logic signed [3:0]  via_tab [8];
    logic               vec_changed;
    logic [15:0]        quiet_cnt;
    logic [2:0]         self_idx;

    t_route_report expected_reports [$];
    t_route_report head_report;
    int errors = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;

    distance_vector_table_update uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_cmd            (in_cmd),
        .i_sender         (in_sender),
        .i_dest           (in_dest),
        .i_cost_in        (in_cost),
        .i_is_neighbour   (in_nb),
        .i_last           (in_last),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_entry_dest     (out_dest),
        .o_entry_cost     (out_cost),
        .o_entry_via      (out_via),
        .o_changed        (out_changed),
        .o_vector_updated (out_vupd),
        .o_quiet_rounds   (out_quiet)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial begin
        #50_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic signed [15:0] sat_cost(int v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic void reset_table();
        for (int i = 0; i < 8; i++) begin
            cost_tab[i] = dvtu_pkg::CIN_UNKNOWN;
            via_tab[i] = dvtu_pkg::VIA_UNKNOWN;
        end
        vec_changed = 1'b0;
        quiet_cnt = '0;
        self_idx = '0;
    endfunction

    function automatic t_route_report apply_route_item(t_route_item it);
        t_route_report rep;
        int sum;
        int d;
        rep = '0;
        if (it.cmd == dvtu_pkg::CMD_LOAD) begin
            if (it.dest == self_idx) begin
                cost_tab[it.dest] = dvtu_pkg::CIN_SELF;
                via_tab[it.dest] = dvtu_pkg::VIA_SELF;
            end else begin
                cost_tab[it.dest] = it.cost;
                via_tab[it.dest] = it.nb ? $signed({1'b0, it.dest}) : dvtu_pkg::VIA_UNKNOWN;
            end
        end else begin
            if (it.cost != dvtu_pkg::CIN_UNKNOWN && it.cost != dvtu_pkg::CIN_SELF) begin
                sum = int'(it.cost) + int'(cost_tab[it.sender]);
                d = int'(cost_tab[it.dest]);
                if ((sum < d && d != 1) || d == -1) begin
                    cost_tab[it.dest] = sat_cost(sum);
                    via_tab[it.dest] = via_tab[it.sender];
                    rep.changed = 1'b1;
                    vec_changed = 1'b1;
                    quiet_cnt = '0;
                end
            end
            if (it.last) begin
                rep.vupd = vec_changed;
                if (!vec_changed && quiet_cnt != dvtu_pkg::QUIET_MAX) quiet_cnt++;
                vec_changed = 1'b0;
            end
        end
        rep.dest = it.dest;
        rep.cost = cost_tab[it.dest];
        rep.via = via_tab[it.dest];
        rep.quiet = quiet_cnt;
        return rep;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(negedge clk)
        out_stall <= (rx_stall_pct != 0) && ($urandom_range(0, 99) < rx_stall_pct);

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected report, expected none, actual dest %0d cost %0d",
                         $time, out_dest, out_cost);
                errors++;
            end else begin
                head_report = expected_reports.pop_front();
                check_field("entry_dest", int'(head_report.dest), int'(out_dest));
                check_field("entry_cost", int'($signed(head_report.cost)),
                            int'($signed(out_cost)));
                check_field("entry_via", int'($signed(head_report.via)),
                            int'($signed(out_via)));
                check_field("changed", int'(head_report.changed), int'(out_changed));
                check_field("vector_updated", int'(head_report.vupd), int'(out_vupd));
                check_field("quiet_rounds", int'(head_report.quiet), int'(out_quiet));
            end
        end
    end

    task automatic send_item(dvtu_pkg::t_cmd cmd, logic [2:0] snd, logic [2:0] dst,
                             logic signed [15:0] c, logic nb, logic lst);
        t_route_item it;
        it = '{cmd: cmd, sender: snd, dest: dst, cost: c, nb: nb, last: lst};
        @(negedge clk);
        while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        in_cmd    <= cmd;
        in_sender <= snd;
        in_dest   <= dst;
        in_cost   <= c;
        in_nb     <= nb;
        in_last   <= lst;
        do @(posedge clk); while (in_stall);
        expected_reports.push_back(apply_route_item(it));
    endtask

    task automatic stop_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (expected_reports.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_self(logic [2:0] idx);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= idx;
        do @(posedge clk); while (!cfg_ready);
        self_idx = idx;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] pick_cost();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 16'($urandom_range(0, 12));
        if (r < 75) return 16'($urandom_range(0, 32767));
        if (r < 85) return 16'(32767 - $urandom_range(0, 3));
        if (r < 92) return dvtu_pkg::CIN_UNKNOWN;
        return dvtu_pkg::CIN_SELF;
    endfunction

    task automatic test_directed_load();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        send_item(dvtu_pkg::CMD_LOAD, 3'd3, 3'd0, 16'sd5, 1'b1, 1'b0);
        send_item(dvtu_pkg::CMD_LOAD, 3'd0, 3'd1, 16'sd1, 1'b1, 1'b0);
        send_item(dvtu_pkg::CMD_LOAD, 3'd0, 3'd2, 16'sd32767, 1'b0, 1'b0);
        send_item(dvtu_pkg::CMD_LOAD, 3'd0, 3'd3, dvtu_pkg::CIN_UNKNOWN, 1'b0, 1'b0);
        send_item(dvtu_pkg::CMD_LOAD, 3'd0, 3'd4, 16'sd0, 1'b1, 1'b0);
        send_item(dvtu_pkg::CMD_LOAD, 3'd7, 3'd7, dvtu_pkg::CIN_SELF, 1'b1, 1'b1);
        stop_input();
        drain();
    endtask

    task automatic test_directed_advertise();
        tx_idle_pct = 35;
        rx_stall_pct = 35;
        send_item(dvtu_pkg::CMD_ADV, 3'd1, 3'd3, dvtu_pkg::CIN_UNKNOWN, 1'b0, 1'b0);
        send_item(dvtu_pkg::CMD_ADV, 3'd1, 3'd3, dvtu_pkg::CIN_SELF, 1'b0, 1'b0);
        send_item(dvtu_pkg::CMD_ADV, 3'd1, 3'd3, 16'sd4, 1'b0, 1'b0);
        send_item(dvtu_pkg::CMD_ADV, 3'd1, 3'd3, 16'sd4, 1'b0, 1'b1);
        send_item(dvtu_pkg::CMD_ADV, 3'd1, 3'd1, 16'sd0, 1'b0, 1'b1);
        // cost-1 direct link is not replaced even by a cheaper path
        send_item(dvtu_pkg::CMD_ADV, 3'd4, 3'd1, 16'sd0, 1'b1, 1'b1);
        send_item(dvtu_pkg::CMD_ADV, 3'd2, 3'd5, 16'sd32767, 1'b0, 1'b0);
        send_item(dvtu_pkg::CMD_ADV, 3'd2, 3'd6, 16'sd32767, 1'b1, 1'b1);
        send_item(dvtu_pkg::CMD_ADV, 3'd4, 3'd5, 16'sd2, 1'b0, 1'b1);
        send_item(dvtu_pkg::CMD_ADV, 3'd0, 3'd6, 16'sd3, 1'b0, 1'b1);
        send_item(dvtu_pkg::CMD_ADV, 3'd7, 3'd7, 16'sd0, 1'b0, 1'b1);
        stop_input();
        drain();
    endtask

    task automatic test_self_index();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        set_self(3'd7);
        send_item(dvtu_pkg::CMD_LOAD, 3'd0, 3'd7, 16'sd9, 1'b1, 1'b0);
        send_item(dvtu_pkg::CMD_LOAD, 3'd0, 3'd0, 16'sd2, 1'b1, 1'b0);
        stop_input();
        set_self(3'd3);
        send_item(dvtu_pkg::CMD_LOAD, 3'd0, 3'd3, 16'sd4, 1'b0, 1'b0);
        stop_input();
        set_self(3'd0);
    endtask

    task automatic test_quiet_count();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        for (int k = 0; k < 20; k++)
            send_item(dvtu_pkg::CMD_ADV, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                      dvtu_pkg::CIN_UNKNOWN, 1'($urandom), 1'b1);
        send_item(dvtu_pkg::CMD_LOAD, 3'd0, 3'd5, dvtu_pkg::CIN_UNKNOWN, 1'b0, 1'b0);
        send_item(dvtu_pkg::CMD_ADV, 3'd1, 3'd5, 16'sd1, 1'b0, 1'b1);
        for (int k = 0; k < 5; k++)
            send_item(dvtu_pkg::CMD_ADV, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                      dvtu_pkg::CIN_SELF, 1'($urandom), 1'b1);
        stop_input();
        drain();
    endtask

    task automatic test_random_traffic(int n_items, int tx_pct, int rx_pct);
        int sent;
        int r;
        int len;
        logic [2:0] snd;
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 20) begin
                send_item(dvtu_pkg::CMD_LOAD, 3'($urandom_range(0, 7)),
                          3'($urandom_range(0, 7)), pick_cost(), 1'($urandom),
                          1'($urandom));
                sent++;
            end else if (r < 85) begin
                snd = 3'($urandom_range(0, 7));
                len = $urandom_range(1, 8);
                for (int k = 0; k < len; k++) begin
                    send_item(dvtu_pkg::CMD_ADV, snd, 3'($urandom_range(0, 7)), pick_cost(),
                              1'($urandom), k == len - 1);
                    sent++;
                end
            end else begin
                send_item(dvtu_pkg::CMD_ADV, 3'($urandom_range(0, 7)),
                          3'($urandom_range(0, 7)), pick_cost(), 1'($urandom),
                          1'($urandom));
                sent++;
            end
        end
        stop_input();
        drain();
    endtask

    initial begin
        reset_table();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_load();
        test_directed_advertise();
        test_self_index();
        test_quiet_count();

        test_random_traffic(250, 0, 0);
        set_self(3'd7);
        test_random_traffic(250, 67, 0);
        set_self(3'($urandom_range(1, 6)));
        test_random_traffic(250, 0, 67);
        set_self(3'd0);
        test_random_traffic(250, 35, 35);

        drain();
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
